/* rtl/core/totq_pkg.sv */
// ----------------------------------------------------------------------------
// totq_pkg
// Shared types and codes for the tick-ordered turn queue: function codes,
// status codes and the command word broadcast to every queue cell.
// ----------------------------------------------------------------------------
package totq_pkg;

   localparam int ID_W     = 8;
   localparam int FUNC_W   = 2;
   localparam int DELTA_W  = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int FRONT_W  = 32;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESCHED = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD  = 2'd0,
      OP_SHIFT = 2'd1,
      OP_DROP  = 2'd2,
      OP_PLACE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [ID_W-1:0]  id;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PLACE = 2'b10
   } ctrl_state_type;

endpackage

/* rtl/core/totq_cell.sv */
// ----------------------------------------------------------------------------
// totq_cell
// One slot of the sorted queue: holds an id and a due tick, and on command
// shifts in from its left neighbor, pulls from its right neighbor, or takes
// the entry being placed.
// ----------------------------------------------------------------------------
module totq_cell #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                         clock,
   input  totq_pkg::cell_cmd_type       cmd,
   input  logic [TICK_WIDTH-1:0]        cmd_tick,
   input  logic                         occupied,
   input  logic [totq_pkg::ID_W-1:0]    left_id,
   input  logic [TICK_WIDTH-1:0]        left_tick,
   input  logic [totq_pkg::ID_W-1:0]    right_id,
   input  logic [TICK_WIDTH-1:0]        right_tick,
   input  logic                         hit_in,
   output logic                         hit_out,
   input  logic                         le_in,
   output logic                         le_out,
   output logic [totq_pkg::ID_W-1:0]    id_q,
   output logic [TICK_WIDTH-1:0]        tick_q,
   output logic [totq_pkg::ID_W-1:0]    id_next,
   output logic [TICK_WIDTH-1:0]        tick_next,
   output logic [TICK_WIDTH-1:0]        match_tick
);
   import totq_pkg::*;

   logic [ID_W-1:0]       id_ff, id_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic                  match;

   always_comb begin
      match      = occupied && (id_ff == cmd.id) && !hit_in;
      hit_out    = hit_in || match;
      le_out     = occupied && (tick_ff <= cmd_tick);
      match_tick = match ? tick_ff : '0;
   end

   always_comb begin
      id_in   = id_ff;
      tick_in = tick_ff;
      case (cmd.op)
         OP_SHIFT: begin
            id_in   = left_id;
            tick_in = left_tick;
         end
         OP_DROP: begin
            // close the gap behind the removed entry
            if (hit_out) begin
               id_in   = right_id;
               tick_in = right_tick;
            end
         end
         OP_PLACE: begin
            if (!le_out) begin
               if (le_in) begin
                  id_in   = cmd.id;
                  tick_in = cmd_tick;
               end else begin
                  id_in   = left_id;
                  tick_in = left_tick;
               end
            end
         end
         default: begin
            id_in   = id_ff;
            tick_in = tick_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      tick_ff <= tick_in;
   end

   assign id_q      = id_ff;
   assign tick_q    = tick_ff;
   assign id_next   = id_in;
   assign tick_next = tick_in;

endmodule

/* rtl/core/tick_ordered_turn_queue_core.sv */
// ----------------------------------------------------------------------------
// tick_ordered_turn_queue_core
// Turn queue of up to DEPTH actors kept sorted by ascending due tick in a
// chain of cells; clears to one id-0 entry, adds at front, reschedules by id.
// ----------------------------------------------------------------------------
//  channel | direction | word fields (lowest bit up)
//  req_    | in        | func[1:0] actor_id[9:2] delta[25:10], zero pad to 32
//  rsp_    | out       | front_id[7:0] front_tick[39:8] entry_count[44:40]
//          |           | status[46:45], zero pad to 48
//
// Clear, add and unknown codes finish in ST_IDLE; a reschedule first finds and
// pulls the entry out of the chain, then places it back in ST_PLACE. A
// reschedule of an unknown id finishes in ST_IDLE. Reset is synchronous and
// empties the queue. A new word is taken only when the control is idle and
// the result register is empty or being read in the same cycle.
// ----------------------------------------------------------------------------
module tick_ordered_turn_queue_core #(
   parameter int DEPTH      = 16,
   parameter int TICK_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // func, actor_id, delta
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // front_id, front_tick, entry_count, status
);
   import totq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = ((TICK_WIDTH > DELTA_W) ? TICK_WIDTH : DELTA_W) + 1;
   localparam int FT_W  = (TICK_WIDTH > FRONT_W) ? TICK_WIDTH : FRONT_W;

   logic [FUNC_W-1:0]  req_func;
   logic [ID_W-1:0]    req_id;
   logic [DELTA_W-1:0] req_delta;
   logic               accept;

   ctrl_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ID_W-1:0]    new_id_ff, new_id_in;
   logic [TICK_WIDTH-1:0] new_tick_ff, new_tick_in;

   logic               out_valid_ff, out_valid_in;
   logic [ID_W-1:0]    out_id_ff, out_id_in;
   logic [FRONT_W-1:0] out_tick_ff, out_tick_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic               load_out;
   logic [STATUS_W-1:0] status;

   cell_cmd_type       cmd;
   logic [TICK_WIDTH-1:0] cmd_tick;

   logic [ID_W-1:0]       id_q [DEPTH];
   logic [TICK_WIDTH-1:0] tick_q [DEPTH];
   logic [ID_W-1:0]       id_nx [DEPTH];
   logic [TICK_WIDTH-1:0] tick_nx [DEPTH];
   logic [TICK_WIDTH-1:0] m_tick [DEPTH];
   logic [DEPTH:0]        hit;
   logic [DEPTH:0]        le;
   logic [TICK_WIDTH-1:0] removed_tick;
   logic [SUM_W-1:0]      sum;
   logic [FT_W-1:0]       front_wide;

   assign req_func  = req_tdata[1:0];
   assign req_id    = req_tdata[9:2];
   assign req_delta = req_tdata[25:10];

   assign req_tready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign hit[0] = 1'b0;
   assign le[0]  = 1'b1;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [ID_W-1:0]       l_id, r_id;
         logic [TICK_WIDTH-1:0] l_tick, r_tick;
         if (gi == 0) begin : g_head
            assign l_id   = cmd.id;
            assign l_tick = '0;
         end else begin : g_body
            assign l_id   = id_q[gi-1];
            assign l_tick = tick_q[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign r_id   = '0;
            assign r_tick = '0;
         end else begin : g_mid
            assign r_id   = id_q[gi+1];
            assign r_tick = tick_q[gi+1];
         end

         totq_cell #(
            .TICK_WIDTH (TICK_WIDTH)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cmd_tick   (cmd_tick),
            .occupied   (CNT_W'(gi) < count_ff),
            .left_id    (l_id),
            .left_tick  (l_tick),
            .right_id   (r_id),
            .right_tick (r_tick),
            .hit_in     (hit[gi]),
            .hit_out    (hit[gi+1]),
            .le_in      (le[gi]),
            .le_out     (le[gi+1]),
            .id_q       (id_q[gi]),
            .tick_q     (tick_q[gi]),
            .id_next    (id_nx[gi]),
            .tick_next  (tick_nx[gi]),
            .match_tick (m_tick[gi])
         );
      end
   endgenerate

   // at most one cell matches, so OR the candidates together
   always_comb begin
      removed_tick = '0;
      for (int k = 0; k < DEPTH; k++) begin
         removed_tick = removed_tick | m_tick[k];
      end
   end

   always_comb begin
      sum = SUM_W'(removed_tick) + SUM_W'(req_delta);
      if (sum[SUM_W-1:TICK_WIDTH] != '0) begin
         new_tick_in = '1;
      end else begin
         new_tick_in = sum[TICK_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      new_id_in = new_id_ff;
      cmd.op    = OP_HOLD;
      cmd.id    = req_id;
      cmd_tick  = new_tick_ff;
      load_out  = 1'b0;
      status    = STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_CLEAR: begin
                     cmd.op   = OP_SHIFT;
                     cmd.id   = '0;
                     count_in = CNT_W'(1);
                     load_out = 1'b1;
                  end
                  FUNC_ADD: begin
                     load_out = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status = STAT_FULL;
                     end else begin
                        cmd.op   = OP_SHIFT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_RESCHED: begin
                     if (hit[DEPTH]) begin
                        cmd.op    = OP_DROP;
                        count_in  = count_ff - CNT_W'(1);
                        new_id_in = req_id;
                        state_in  = ST_PLACE;
                     end else begin
                        status   = STAT_MISSING;
                        load_out = 1'b1;
                     end
                  end
                  default: begin
                     load_out = 1'b1;
                  end
               endcase
            end
         end
         ST_PLACE: begin
            cmd.op   = OP_PLACE;
            cmd.id   = new_id_ff;
            count_in = count_ff + CNT_W'(1);
            load_out = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      front_wide    = FT_W'(tick_nx[0]);
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_id_in     = out_id_ff;
      out_tick_in   = out_tick_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      if (load_out) begin
         out_valid_in  = 1'b1;
         out_count_in  = COUNT_W'(count_in);
         out_status_in = status;
         if (count_in == '0) begin
            out_id_in   = '0;
            out_tick_in = '0;
         end else begin
            out_id_in   = id_nx[0];
            out_tick_in = front_wide[FRONT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_id_ff     <= new_id_in;
      out_id_ff     <= out_id_in;
      out_tick_ff   <= out_tick_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
      if (accept) begin
         new_tick_ff <= new_tick_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_status_ff, out_count_ff, out_tick_ff, out_id_ff};

endmodule
